/* design/rctm_pkg.sv */
package rctm_pkg;

  typedef struct packed {
    logic               hit_side;
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [23:0]        wall_dist;
    logic [15:0]        line_height;
    logic [8:0]         row;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  pixel_kind;
    logic [31:0] color;
    logic [1:0]  face_select;
    logic [5:0]  tex_row;
    logic [5:0]  tex_col;
    logic [11:0] texel_address;
  } out_word_t;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 2'd1;

  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_FLOOR   = 2'd2;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

endpackage

/* design/rctm_divider.sv */
// Restoring divider, one quotient bit per stage. Needs num < den * 2^QW.
module rctm_divider #(
  parameter int QW = 7,
  parameter int NW = 24,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW-1];
  logic [QW-1:0] num_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num[QW+DW-1:QW];
      assign num_in = num[QW-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial   = {rem_in, num_in[QW-1-i]};
    assign ge      = trial >= {1'b0, den_in};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
    assign q_nxt   = {q_in[QW-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          num_r[i] <= num_in;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

/* design/raycast_column_texel_mapper.sv */
// channel | dir | handshake           | word
// in_     | in  | in_valid / in_stall   | rctm_pkg::in_word_t, one pixel
// out_    | out | out_valid / out_stall | rctm_pkg::out_word_t, one result
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (colours)
//
// One word accepted per clock unless a stalled result holds the pipeline; the
// stages are A, B, the texture-row divider at one quotient bit a stage, output.
// rst_n is synchronous; it clears valid bits and the colour registers.
// A stall on the output holds every stage; in_stall follows it when out_valid.
module raycast_column_texel_mapper #(
  parameter int SCREEN_HEIGHT = 512,
  parameter int TEX_SIZE      = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rctm_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rctm_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rctm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int CW = $clog2(TEX_SIZE);
  localparam int QW = $clog2(TEX_SIZE + 1);
  localparam int KW = 17;
  localparam int NW = KW + QW;
  localparam int AW = 2 * QW + 1;
  localparam int PW = 16 + QW;
  localparam logic signed [17:0] HALF_S  = 18'(SCREEN_HEIGHT / 2);
  localparam logic signed [17:0] LAST_S  = 18'(SCREEN_HEIGHT - 1);
  localparam logic [QW-1:0]      TEX_Q   = QW'(TEX_SIZE);
  localparam logic [CW-1:0]      COL_MAX = CW'(TEX_SIZE - 1);

  typedef struct packed {
    logic          valid;
    logic [1:0]    kind;
    logic [31:0]   color;
    logic [1:0]    face;
    logic [CW-1:0] col;
  } side_t;

  logic        en;
  logic [31:0] ceiling_color_r;
  logic [31:0] floor_color_r;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rctm_pkg::CFG_CEILING_COLOR: ceiling_color_r <= cfg_data;
        rctm_pkg::CFG_FLOOR_COLOR:   floor_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: span, kind, face, multiply
  logic               out_valid_r;
  logic [15:0]        lh_sat;
  logic signed [17:0] half_lh;
  logic signed [17:0] row_s;
  logic signed [17:0] start_s;
  logic signed [17:0] end_s;
  logic signed [17:0] end_clip;
  logic signed [17:0] k_full;
  logic signed [24:0] dist_s;
  logic signed [15:0] dir_sel;
  logic signed [40:0] prod;
  logic [1:0]         a_kind_nxt;
  logic [31:0]        a_color_nxt;
  logic [1:0]         a_face_nxt;
  logic               a_mirror_nxt;
  logic [15:0]        a_pos_nxt;

  logic               a_valid_r;
  logic [1:0]         a_kind_r;
  logic [31:0]        a_color_r;
  logic [1:0]         a_face_r;
  logic               a_mirror_r;
  logic [15:0]        a_pos_r;
  logic [15:0]        a_prod_r;
  logic [15:0]        a_lh_r;
  logic [KW-1:0]      a_k_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign lh_sat   = (in_word.line_height == 16'd0) ? 16'd1 : in_word.line_height;
  assign half_lh  = signed'({3'b000, lh_sat[15:1]});
  assign row_s    = signed'({9'd0, in_word.row});
  assign start_s  = HALF_S - half_lh;
  assign end_s    = HALF_S + half_lh;
  assign end_clip = (end_s > LAST_S) ? LAST_S : end_s;
  assign k_full   = row_s - HALF_S + half_lh;

  always_comb begin
    if (row_s < start_s) begin
      a_kind_nxt  = rctm_pkg::KIND_CEILING;
      a_color_nxt = ceiling_color_r;
    end else if (row_s <= end_clip) begin
      a_kind_nxt  = rctm_pkg::KIND_WALL;
      a_color_nxt = '0;
    end else begin
      a_kind_nxt  = rctm_pkg::KIND_FLOOR;
      a_color_nxt = floor_color_r;
    end

    if (!in_word.hit_side && in_word.ray_dir_x < 0) begin
      a_face_nxt = rctm_pkg::FACE_EAST;
    end else if (!in_word.hit_side && in_word.ray_dir_x > 0) begin
      a_face_nxt = rctm_pkg::FACE_WEST;
    end else if (in_word.hit_side && in_word.ray_dir_y > 0) begin
      a_face_nxt = rctm_pkg::FACE_SOUTH;
    end else begin
      a_face_nxt = rctm_pkg::FACE_NORTH;
    end

    if (!in_word.hit_side) begin
      a_mirror_nxt = in_word.ray_dir_x > 0;
      a_pos_nxt    = in_word.pos_y[15:0];
      dir_sel      = in_word.ray_dir_y;
    end else begin
      a_mirror_nxt = in_word.ray_dir_y < 0;
      a_pos_nxt    = in_word.pos_x[15:0];
      dir_sel      = in_word.ray_dir_x;
    end
  end

  assign dist_s = signed'({1'b0, in_word.wall_dist});
  assign prod   = dist_s * dir_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r   <= a_kind_nxt;
      a_color_r  <= a_color_nxt;
      a_face_r   <= a_face_nxt;
      a_mirror_r <= a_mirror_nxt;
      a_pos_r    <= a_pos_nxt;
      a_prod_r   <= prod[29:14];
      a_lh_r     <= lh_sat;
      a_k_r      <= k_full[KW-1:0];
    end
  end

  // stage B: texture column, row numerator
  logic [15:0]   frac;
  logic [PW-1:0] col_prod;
  logic [CW-1:0] col_raw;
  side_t         b_side_nxt;
  side_t         b_side_r;
  logic [NW-1:0] b_num_r;
  logic [15:0]   b_lh_r;

  assign frac     = a_pos_r + a_prod_r;
  assign col_prod = {{QW{1'b0}}, frac} * PW'(TEX_SIZE);
  assign col_raw  = col_prod[16+CW-1:16];

  always_comb begin
    b_side_nxt.valid = a_valid_r;
    b_side_nxt.kind  = a_kind_r;
    b_side_nxt.color = a_color_r;
    b_side_nxt.face  = a_face_r;
    b_side_nxt.col   = a_mirror_r ? (COL_MAX - col_raw) : col_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_side_r.valid <= 1'b0;
    end else if (en) begin
      b_side_r.valid <= b_side_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r.kind  <= b_side_nxt.kind;
      b_side_r.color <= b_side_nxt.color;
      b_side_r.face  <= b_side_nxt.face;
      b_side_r.col   <= b_side_nxt.col;
      b_num_r        <= {{QW{1'b0}}, a_k_r} * NW'(TEX_SIZE);
      b_lh_r         <= a_lh_r;
    end
  end

  // divider stages, side data delayed alongside
  logic [QW-1:0] quo;
  side_t         dly_r [QW];

  rctm_divider #(
    .QW(QW),
    .NW(NW),
    .DW(16)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(b_num_r),
    .den(b_lh_r),
    .quo(quo)
  );

  for (genvar i = 0; i < QW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dly_r[i] <= '0;
      end else if (en) begin
        dly_r[i] <= (i == 0) ? b_side_r : dly_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // output register
  logic [QW-1:0]       trow_full;
  logic [AW-1:0]       addr_full;
  rctm_pkg::out_word_t out_nxt;
  rctm_pkg::out_word_t out_word_r;
  side_t               last;

  assign last      = dly_r[QW-1];
  assign trow_full = (quo == TEX_Q) ? '0 : quo;
  assign addr_full = AW'(trow_full) * AW'(TEX_SIZE) + AW'(last.col);

  always_comb begin
    out_nxt.pixel_kind  = last.kind;
    out_nxt.color       = last.color;
    out_nxt.face_select = last.face;
    if (last.kind == rctm_pkg::KIND_WALL) begin
      out_nxt.tex_row       = 6'(trow_full);
      out_nxt.tex_col       = 6'(last.col);
      out_nxt.texel_address = 12'(addr_full);
    end else begin
      out_nxt.tex_row       = '0;
      out_nxt.tex_col       = '0;
      out_nxt.texel_address = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* design/rctm_checker.sv */
module rctm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rctm_pkg::out_word_t out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  // input only held back by a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.pixel_kind == rctm_pkg::KIND_CEILING ||
                  out_word.pixel_kind == rctm_pkg::KIND_WALL ||
                  out_word.pixel_kind == rctm_pkg::KIND_FLOOR)
    else $error("bad pixel kind");

  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.pixel_kind != rctm_pkg::KIND_WALL |->
      out_word.tex_row == '0 && out_word.tex_col == '0 && out_word.texel_address == '0)
    else $error("texture fields set on ceiling or floor pixel");

  a_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.pixel_kind == rctm_pkg::KIND_WALL |-> out_word.color == '0)
    else $error("colour set on wall pixel");

endmodule

bind raycast_column_texel_mapper rctm_checker u_rctm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

/* dv/tb_raycast_column_texel_mapper.sv */
module tb_raycast_column_texel_mapper;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_H       = 512;
  localparam int TEX_W       = 64;
  localparam int PIPE_LAT    = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 150;

  typedef struct {
    rctm_pkg::in_word_t  pix;
    bit                  typed;
    rctm_pkg::out_word_t res;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  rctm_pkg::in_word_t             in_word = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rctm_pkg::out_word_t            out_word;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rctm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  logic [31:0]         ceil_colour = '0;
  logic [31:0]         floor_colour = '0;
  rctm_pkg::out_word_t texel_q[$];
  stim_row_t           stim_table[$];
  bit                  cur_typed = 1'b0;
  rctm_pkg::out_word_t cur_res = '0;
  bit                  idle_en = 1'b1;
  int                  hold_req = 0;
  int                  hold_left = 0;
  int                  mismatches = 0;
  int                  cycles = 0;

  raycast_column_texel_mapper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic rctm_pkg::out_word_t predict_texel(rctm_pkg::in_word_t w);
    longint    lh, span_lo, span_hi, r, prod, num;
    logic [63:0] pos, sum;
    logic [5:0]  col;
    bit          mirror;
    rctm_pkg::out_word_t o;
    o = '0;
    lh = (w.line_height == 0) ? 1 : longint'(w.line_height);
    if (w.hit_side == 1'b0 && $signed(w.ray_dir_x) < 0) o.face_select = rctm_pkg::FACE_EAST;
    else if (w.hit_side == 1'b0 && $signed(w.ray_dir_x) > 0)
      o.face_select = rctm_pkg::FACE_WEST;
    else if (w.hit_side == 1'b1 && $signed(w.ray_dir_y) > 0)
      o.face_select = rctm_pkg::FACE_SOUTH;
    else o.face_select = rctm_pkg::FACE_NORTH;
    span_lo = SCR_H / 2 - lh / 2;
    span_hi = SCR_H / 2 + lh / 2;
    if (span_lo < 0) span_lo = 0;
    if (span_hi >= SCR_H) span_hi = SCR_H - 1;
    r = longint'(w.row);
    if (r < span_lo) begin
      o.pixel_kind = rctm_pkg::KIND_CEILING;
      o.color = ceil_colour;
    end else if (r <= span_hi) begin
      o.pixel_kind = rctm_pkg::KIND_WALL;
      if (w.hit_side == 1'b0) begin
        prod = longint'(w.wall_dist) * longint'($signed(w.ray_dir_y));
        pos = 64'(w.pos_y);
        mirror = $signed(w.ray_dir_x) > 0;
      end else begin
        prod = longint'(w.wall_dist) * longint'($signed(w.ray_dir_x));
        pos = 64'(w.pos_x);
        mirror = $signed(w.ray_dir_y) < 0;
      end
      sum = pos + 64'(prod >>> 14);
      col = sum[15:10];
      if (mirror) col = 6'd63 - col;
      num = (r - SCR_H / 2 + lh / 2) * TEX_W;
      if (num < 0) num = 0;
      o.tex_row = 6'((num / lh) % TEX_W);
      o.tex_col = col;
      o.texel_address = {o.tex_row, o.tex_col};
    end else begin
      o.pixel_kind = rctm_pkg::KIND_FLOOR;
      o.color = floor_colour;
    end
    return o;
  endfunction

  function automatic rctm_pkg::in_word_t mk_pix(bit side, logic [23:0] px, logic [23:0] py,
                                                logic [15:0] dx, logic [15:0] dy,
                                                logic [23:0] w_dist, logic [15:0] lh,
                                                logic [8:0] r);
    rctm_pkg::in_word_t w;
    w.hit_side = side;
    w.pos_x = px;
    w.pos_y = py;
    w.ray_dir_x = dx;
    w.ray_dir_y = dy;
    w.wall_dist = w_dist;
    w.line_height = lh;
    w.row = r;
    return w;
  endfunction

  function automatic rctm_pkg::out_word_t mk_res(logic [1:0] kind, logic [31:0] colour,
                                                 logic [1:0] face, logic [5:0] trow,
                                                 logic [5:0] tcol, logic [11:0] addr);
    rctm_pkg::out_word_t o;
    o.pixel_kind = kind;
    o.color = colour;
    o.face_select = face;
    o.tex_row = trow;
    o.tex_col = tcol;
    o.texel_address = addr;
    return o;
  endfunction

  function automatic logic [15:0] rand_dir();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 16'h0000;
    if (sel < 15) return 16'h8000;
    if (sel < 20) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  function automatic rctm_pkg::in_word_t rand_pixel();
    rctm_pkg::in_word_t w;
    int lh, lo, hi;
    w.hit_side = 1'($urandom_range(1));
    w.pos_x = 24'($urandom);
    w.pos_y = 24'($urandom);
    w.ray_dir_x = rand_dir();
    w.ray_dir_y = rand_dir();
    w.wall_dist = ($urandom_range(3) == 0) ? 24'($urandom_range(65535)) : 24'($urandom);
    w.line_height = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(600));
    lh = (w.line_height == 0) ? 1 : int'(w.line_height);
    lo = SCR_H / 2 - lh / 2;
    hi = SCR_H / 2 + lh / 2;
    if (lo < 0) lo = 0;
    if (hi >= SCR_H) hi = SCR_H - 1;
    if ($urandom_range(1)) w.row = 9'($urandom_range(hi, lo));
    else w.row = 9'($urandom);
    return w;
  endfunction

  task automatic load_table();
    stim_row_t s;
    s.typed = 1'b1;
    s.pix = mk_pix(0, 0, 0, 16'hFFFF, 0, 0, 2, 0);
    s.res = mk_res(rctm_pkg::KIND_CEILING, 0, rctm_pkg::FACE_EAST, 0, 0, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 0, 0, 0, 1, 0, 2, 511);
    s.res = mk_res(rctm_pkg::KIND_FLOOR, 0, rctm_pkg::FACE_SOUTH, 0, 0, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 0, 0, 0, 0, 0, 256);
    s.res = mk_res(rctm_pkg::KIND_WALL, 0, rctm_pkg::FACE_NORTH, 0, 0, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 24'hFFFFFF, 0, 0, 0, 0, 256);
    s.res = mk_res(rctm_pkg::KIND_WALL, 0, rctm_pkg::FACE_NORTH, 0, 63, 63);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 0, 1, 0, 0, 0, 256);
    s.res = mk_res(rctm_pkg::KIND_WALL, 0, rctm_pkg::FACE_WEST, 0, 63, 63);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 0, 0, 0, 16'h8000, 0, 0, 256);
    s.res = mk_res(rctm_pkg::KIND_WALL, 0, rctm_pkg::FACE_NORTH, 0, 63, 63);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'hFFFFFF, 0, 16'h7FFF, 0, 0, 0, 256);
    s.res = mk_res(rctm_pkg::KIND_WALL, 0, rctm_pkg::FACE_NORTH, 0, 63, 63);
    stim_table.push_back(s);

    s.typed = 1'b0;
    s.res = '0;
    s.pix = mk_pix(0, 24'hFFFFFF, 24'hABCDEF, 16'h8000, 16'h8000, 24'hFFFFFF, 16'hFFFF, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'h123456, 24'hFFFFFF, 16'h7FFF, 16'h7FFF, 24'hFFFFFF, 16'hFFFF, 511);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'h800000, 0, 16'h8000, 16'h7FFF, 24'hFFFFFF, 16'hFFFF, 300);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 24'h00FFFF, 16'h8000, 16'h4000, 24'h010000, 1, 255);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 24'h00FFFF, 16'h8000, 16'h4000, 24'h010000, 1, 256);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 0, 24'h00FFFF, 16'h8000, 16'h4000, 24'h010000, 1, 257);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'hFFFF00, 0, 16'hC000, 16'hFFFF, 24'h7FFFFF, 511, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'hFFFF00, 0, 16'hC000, 16'hFFFF, 24'h7FFFFF, 511, 511);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 24'hAAAAAA, 24'h555555, 16'h0001, 16'hFFFF, 24'h000001, 512, 0);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 24'hAAAAAA, 24'h555555, 16'h0001, 16'hFFFF, 24'h000001, 512, 511);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'h555555, 24'hAAAAAA, 16'h2000, 16'h0001, 24'h345678, 3, 257);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 24'h000001, 24'h7FFFFF, 0, 16'h8001, 24'hFFFF00, 2, 255);
    stim_table.push_back(s);
    s.pix = mk_pix(1, 24'h3C0000, 24'h000000, 16'hFFFF, 0, 24'h00C000, 2, 257);
    stim_table.push_back(s);
    s.pix = mk_pix(0, 24'hFFFFFF, 24'h000000, 16'h8000, 16'h7FFF, 24'h800000, 16'h8000, 300);
    stim_table.push_back(s);
  endtask

  task automatic send_item(rctm_pkg::in_word_t w, bit typed, rctm_pkg::out_word_t res);
    while (idle_en && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    cur_typed <= typed;
    cur_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [rctm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (texel_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      texel_q.push_back(cur_typed ? cur_res : predict_texel(in_word));
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        rctm_pkg::CFG_CEILING_COLOR: ceil_colour <= cfg_data;
        rctm_pkg::CFG_FLOOR_COLOR:   floor_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    rctm_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (texel_q.size() == 0) begin
        $error("unexpected output word %h", out_word);
        mismatches++;
      end else begin
        e = texel_q.pop_front();
        if (out_word.pixel_kind !== e.pixel_kind) begin
          $error("pixel_kind exp %0d got %0d", e.pixel_kind, out_word.pixel_kind);
          mismatches++;
        end
        if (out_word.color !== e.color) begin
          $error("color exp %h got %h", e.color, out_word.color);
          mismatches++;
        end
        if (out_word.face_select !== e.face_select) begin
          $error("face_select exp %0d got %0d", e.face_select, out_word.face_select);
          mismatches++;
        end
        if (out_word.tex_row !== e.tex_row) begin
          $error("tex_row exp %0d got %0d", e.tex_row, out_word.tex_row);
          mismatches++;
        end
        if (out_word.tex_col !== e.tex_col) begin
          $error("tex_col exp %0d got %0d", e.tex_col, out_word.tex_col);
          mismatches++;
        end
        if (out_word.texel_address !== e.texel_address) begin
          $error("texel_address exp %0d got %0d", e.texel_address, out_word.texel_address);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** raycast_column_texel_mapper: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] ceil_set[6];
    logic [31:0] floor_set[6];
    ceil_set = '{32'hFFFFFFFF, 32'h0, $urandom, 32'hFFFFFFFF, $urandom, 32'h0};
    floor_set = '{32'h0, 32'hFFFFFFFF, $urandom, 32'hFFFFFFFF, $urandom, 32'h0};
    load_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset colours still in place for the table
    foreach (stim_table[i]) send_item(stim_table[i].pix, stim_table[i].typed, stim_table[i].res);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rctm_pkg::CFG_CEILING_COLOR, ceil_set[ph]);
      write_reg(rctm_pkg::CFG_FLOOR_COLOR, floor_set[ph]);
      cfg_valid <= 1'b0;
      idle_en = (ph != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 3 && n == 20) hold_req = 300;
        if (ph == 4 && n == 75) wait_drained();
        send_item(rand_pixel(), 1'b0, '0);
      end
      wait_drained();
    end

    if (mismatches == 0 && texel_q.size() == 0) begin
      $display("** raycast_column_texel_mapper: PASSED **");
    end else begin
      $display("** raycast_column_texel_mapper: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rctm_pkg.sv
design/rctm_divider.sv
design/raycast_column_texel_mapper.sv
design/rctm_checker.sv
dv/tb_raycast_column_texel_mapper.sv
